>>> rtl/core/lcd_bar_graph_glyphs_defines.svh
// Assertion macros shared by the bar graph checker.
`ifndef LCD_BAR_GRAPH_GLYPHS_DEFINES_SVH
`define LCD_BAR_GRAPH_GLYPHS_DEFINES_SVH

// Checked on every clock edge outside reset.
`define LBG_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LBG_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/lbg_pkg.sv
// Types, constants and helpers shared by the bar graph glyph generator.
package lbg_pkg;

  localparam int MAX_CELLS = 20;
  localparam int VAL_W     = 24;
  localparam int CELL_W    = $clog2(MAX_CELLS + 1);
  localparam int FACT_W    = $clog2(MAX_CELLS * 5 + 1);
  localparam int NUM_W     = VAL_W + FACT_W;
  localparam int CNT_W     = $clog2(NUM_W);

  localparam logic [7:0] GLYPH_FULL  = 8'd4;
  localparam logic [7:0] GLYPH_EMPTY = 8'd45;
  localparam logic [7:0] GLYPH_NEG   = 8'd255;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] range_min;
    logic signed [VAL_W-1:0] range_max;
    logic [4:0]              start_col;
    logic [1:0]              row;
    logic [4:0]              bar_length;
    logic                    centered;
  } lbg_in_t;

  typedef struct packed {
    logic [5:0] column;
    logic [1:0] cell_row;
    logic [7:0] glyph;
    logic       last;
  } lbg_out_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic div_step;
    logic fin;
    logic emit;
  } lbg_cmd_t;

  typedef struct packed {
    logic no_cells;
    logic last_cell;
  } lbg_sts_t;

  // Glyph for a partly filled cell holding rem fifths.
  function automatic logic [7:0] partial_glyph(input logic [2:0] rem);
    logic [7:0] g;
    case (rem)
      3'd1:    g = 8'd0;
      3'd2:    g = 8'd1;
      3'd3:    g = 8'd2;
      3'd4:    g = 8'd3;
      default: g = GLYPH_EMPTY;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/core/lbg_datapath.sv
// Datapath: operand setup, fill multiply, restoring divider and cell generation.
module lbg_datapath
  import lbg_pkg::*;
(
  input  logic     clk,
  input  lbg_cmd_t cmd,
  output lbg_sts_t sts,
  input  lbg_in_t  in_data,
  output lbg_out_t out_data
);

  lbg_in_t              in_r;
  logic                 neg_r;
  logic                 q_ok_r;
  logic [CELL_W-1:0]    cells_r;
  logic [FACT_W-1:0]    fact_r;
  logic [VAL_W-1:0]     fill_r;
  logic [VAL_W-1:0]     range_r;
  logic [5:0]           base_r;
  logic [NUM_W-1:0]     num_r;
  logic [VAL_W-1:0]     rem_r;
  logic [CELL_W-1:0]    whole_r;
  logic [2:0]           frac_r;
  logic [CELL_W-1:0]    idx_r;
  lbg_out_t             out_r;

  // Setup stage signals.
  logic [CELL_W-1:0]       len_sat;
  logic [CELL_W-1:0]       half;
  logic signed [VAL_W+1:0] val_e;
  logic signed [VAL_W+1:0] mag_e;
  logic signed [VAL_W+1:0] rmin_e;
  logic signed [VAL_W+1:0] rmax_e;
  logic signed [VAL_W+1:0] range_e;
  logic signed [VAL_W+1:0] fill_e;
  logic                    range_pos;
  logic                    neg_c;
  logic [CELL_W-1:0]       cells_c;
  logic [FACT_W-1:0]       fact_c;
  logic [5:0]              base_c;

  always_comb begin
    if (int'(in_r.bar_length) > MAX_CELLS) begin
      len_sat = CELL_W'(MAX_CELLS);
    end else begin
      len_sat = CELL_W'(in_r.bar_length);
    end
    half      = len_sat >> 1;
    val_e     = {{2{in_r.value[VAL_W-1]}}, in_r.value};
    rmin_e    = {{2{in_r.range_min[VAL_W-1]}}, in_r.range_min};
    rmax_e    = {{2{in_r.range_max[VAL_W-1]}}, in_r.range_max};
    mag_e     = in_r.value[VAL_W-1] ? -val_e : val_e;
    range_e   = rmax_e - rmin_e;
    range_pos = (range_e > 0);
    if (!in_r.centered) begin
      neg_c   = 1'b0;
      cells_c = len_sat;
      fact_c  = FACT_W'(len_sat * 5);
      base_c  = 6'(in_r.start_col);
      if (mag_e >= rmax_e) begin
        fill_e = range_e;
      end else if (mag_e >= rmin_e) begin
        fill_e = mag_e - rmin_e;
      end else begin
        fill_e = '0;
      end
    end else if (in_r.value[VAL_W-1] && range_pos) begin
      // Negative side grows leftward from the centre in whole cells only.
      neg_c   = 1'b1;
      cells_c = half;
      fact_c  = FACT_W'(half);
      base_c  = 6'(in_r.start_col) + 6'(half) - 6'd1;
      fill_e  = mag_e;
    end else begin
      neg_c   = 1'b0;
      cells_c = half;
      fact_c  = FACT_W'(half * 5);
      base_c  = 6'(in_r.start_col) + 6'(half);
      fill_e  = val_e;
    end
  end

  // Divider step.
  logic [VAL_W:0]   trial;
  logic [VAL_W+1:0] diff;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, range_r};

  // Final scaling of the quotient into whole cells and a fifth remainder.
  logic [NUM_W-1:0]    q;
  logic [FACT_W-1:0]   qs;
  logic [FACT_W+7:0]   recip;
  logic [CELL_W-1:0]   whole_c;
  logic [CELL_W-1:0]   div5;
  logic [FACT_W-1:0]   div5_x5;
  logic [2:0]          frac_c;

  always_comb begin
    q       = q_ok_r ? num_r : '0;
    qs      = q[FACT_W-1:0];
    // Multiply by 205/1024, exact for quotients below one thousand.
    recip   = {8'b0, qs} * (FACT_W + 8)'(205);
    div5    = CELL_W'(recip >> 10);
    div5_x5 = FACT_W'(div5) + FACT_W'({div5, 2'b00});
    whole_c = div5;
    frac_c  = 3'(qs - div5_x5);
    if (neg_r) begin
      frac_c = 3'd0;
      if (q >= NUM_W'(cells_r)) begin
        whole_c = cells_r;
      end else begin
        whole_c = q[CELL_W-1:0];
      end
    end else if (q >= NUM_W'(fact_r)) begin
      whole_c = cells_r;
      frac_c  = 3'd0;
    end
  end

  // Cell generation.
  lbg_out_t cell_c;

  always_comb begin
    cell_c.cell_row = in_r.row;
    cell_c.last     = sts.last_cell;
    if (neg_r) begin
      cell_c.column = base_r - 6'(idx_r);
      cell_c.glyph  = (idx_r < whole_r) ? GLYPH_NEG : GLYPH_EMPTY;
    end else begin
      cell_c.column = base_r + 6'(idx_r);
      if (idx_r < whole_r) begin
        cell_c.glyph = GLYPH_FULL;
      end else if (idx_r == whole_r) begin
        cell_c.glyph = partial_glyph(frac_r);
      end else begin
        cell_c.glyph = GLYPH_EMPTY;
      end
    end
  end

  assign sts.no_cells  = (cells_r == '0);
  assign sts.last_cell = (idx_r == cells_r - CELL_W'(1));
  assign out_data      = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.prep) begin
      neg_r   <= neg_c;
      q_ok_r  <= range_pos && (fill_e > 0);
      cells_r <= cells_c;
      fact_r  <= fact_c;
      fill_r  <= fill_e[VAL_W-1:0];
      range_r <= range_e[VAL_W-1:0];
      base_r  <= base_c;
    end
    if (cmd.mul) begin
      num_r <= {{FACT_W{1'b0}}, fill_r} * {{VAL_W{1'b0}}, fact_r};
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      if (!diff[VAL_W+1]) begin
        rem_r <= diff[VAL_W-1:0];
        num_r <= {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[VAL_W-1:0];
        num_r <= {num_r[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.fin) begin
      whole_r <= whole_c;
      frac_r  <= frac_c;
      idx_r   <= '0;
    end
    if (cmd.emit) begin
      out_r <= cell_c;
      idx_r <= idx_r + CELL_W'(1);
    end
  end

endmodule

>>> rtl/core/lbg_ctrl.sv
// Controller: sequences setup, division and cell emission, owns the handshakes.
module lbg_ctrl
  import lbg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  lbg_sts_t sts,
  output lbg_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = '0;
        // A bar of no cells produces no transfer at all.
        state_nxt = sts.no_cells ? S_IDLE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last_cell) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/lcd_bar_graph_glyphs.sv
// Top level of the character LCD bar graph glyph generator.
//
// One input transfer describes a bar: value, range, start column, row, length
// and mode. The block answers with one output transfer per LCD cell of the
// bar, each carrying column, row and glyph code, with last set on the final
// cell. A bar of zero length gives no output transfer.
// Both channels use valid/ready. An input transfer is taken only while the
// block is idle; the last cell of a bar may still sit in the output register
// while the next bar is accepted.
// After the input transfer the block runs setup, the fill multiply, a 31 step
// bit-serial divider and a scaling step before the first cell is presented;
// further cells follow one per cycle while the output register is free. A
// new bar is accepted only once the current bar is finished.
// The output register holds its cell while out_ready is low, and emission
// simply pauses until the cell is taken.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; any bar in progress is discarded.
module lcd_bar_graph_glyphs
  import lbg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lbg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output lbg_out_t out_data
);

  lbg_cmd_t cmd;
  lbg_sts_t sts;

  lbg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lbg_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

>>> rtl/core/lbg_checker.sv
// Port-level checker for the bar graph glyph generator, bound to the top level.
`include "lcd_bar_graph_glyphs_defines.svh"

module lbg_checker
  import lbg_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input lbg_out_t out_data
);

  `LBG_ASSERT_CLK(a_out_hold,
                  out_valid && !out_ready |=> out_valid && $stable(out_data),
                  "stalled cell changed")

  `LBG_ASSERT_CLK(a_glyph_code,
                  out_valid |-> (out_data.glyph <= GLYPH_FULL) ||
                  (out_data.glyph == GLYPH_EMPTY) || (out_data.glyph == GLYPH_NEG),
                  "glyph code out of set")

  `LBG_ASSERT_CLK(a_busy_in_run, out_valid && !out_data.last |-> !in_ready,
                  "input taken during a run of cells")

  `LBG_ASSERT_ANY(a_reset_clears, !rst_n |=> !out_valid, "out_valid after reset")

endmodule

bind lcd_bar_graph_glyphs lbg_checker u_lbg_checker (.*);
